[rtl/core/gpioc_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// gpioc_pkg: shared types and codes of the GPIO controller
// Transfer payloads, item modes and register word indexes.
// ---------------------------------------------------------------------------
package gpioc_pkg;

   // item modes
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;

   // register word indexes
   localparam logic [3:0] REG_DIR  = 4'd0;
   localparam logic [3:0] REG_MODE = 4'd1;
   localparam logic [3:0] REG_POL  = 4'd2;
   localparam logic [3:0] REG_RISE = 4'd3;
   localparam logic [3:0] REG_FALL = 4'd4;
   localparam logic [3:0] REG_DATA = 4'd5;
   localparam logic [3:0] REG_SET  = 4'd6;
   localparam logic [3:0] REG_CLR  = 4'd7;
   localparam logic [3:0] REG_MASK = 4'd10;
   localparam logic [3:0] REG_EN   = 4'd11;
   localparam logic [3:0] REG_PEND = 4'd12;
   localparam logic [3:0] REG_ACK  = 4'd13;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  reg_index;
      logic [15:0] write_data;
      logic [15:0] pin_levels;
   } req_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic [15:0] pin_drive;
      logic [15:0] pin_output_enable;
      logic        irq_line;
   } rsp_type;

endpackage : gpioc_pkg
`default_nettype wire

[rtl/core/gpio_controller_with_edge_level_irq_unit.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// gpio_controller_with_edge_level_irq_unit: 16-line GPIO controller
// Executes pin sample ticks, register reads and register writes, one result
// per item, with per-line edge or level interrupt latching.
// ---------------------------------------------------------------------------
//   channel   ports                           payload
//   request   req_valid/req_ready/req_data    req_type (mode, index, data, pins)
//   response  rsp_valid/rsp_ready/rsp_data    rsp_type (read, drive, oe, irq)
//
// An item is taken into the input register, executed against the register
// file as it advances and placed in the response register; one item per
// cycle is sustained while the response side does not stall. Synchronous
// reset empties both registers and sets the register file to its reset
// values. A stalled response holds the input register; the request side
// keeps accepting while the input register is free or drains that cycle.
// ---------------------------------------------------------------------------
module gpio_controller_with_edge_level_irq_unit
   import gpioc_pkg::*;
#(
   parameter int LINES = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type step_rsp;
   logic    advance;

   // advance the input item when the response register is free or drains
   assign advance     = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready   = ~in_valid_ff | advance;
   assign in_valid_in = (req_valid & req_ready) | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_ready);

   gpioc_regs #(.LINES(LINES)) u_regs (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req     (in_data_ff),
      .rsp     (step_rsp)
   );

   // hold valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // load payloads on transfer
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule : gpio_controller_with_edge_level_irq_unit
`default_nettype wire

[rtl/core/gpioc_detect.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// gpioc_detect: per-line interrupt event detector
// Flags enabled edges on edge-mode lines and active levels on level-mode lines.
// ---------------------------------------------------------------------------
module gpioc_detect #(
   parameter int LINES = 16
) (
   input  wire logic [LINES-1:0] pins,
   input  wire logic [LINES-1:0] prev_pins,
   input  wire logic [LINES-1:0] rise_en,
   input  wire logic [LINES-1:0] fall_en,
   input  wire logic [LINES-1:0] level_mode,
   input  wire logic [LINES-1:0] polarity,
   output logic      [LINES-1:0] hit
);

   logic [LINES-1:0] rise;
   logic [LINES-1:0] fall;
   logic [LINES-1:0] active;

   // find edges and active levels
   assign rise   = pins & ~prev_pins & rise_en;
   assign fall   = ~pins & prev_pins & fall_en;
   assign active = ~(pins ^ polarity);

   // pick the event kind by line mode
   assign hit = (~level_mode & (rise | fall)) | (level_mode & active);

endmodule : gpioc_detect
`default_nettype wire

[rtl/core/gpioc_regs.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// gpioc_regs: register file and item execution
// Holds line configuration, output latch and pending bits; executes one item
// per step and returns its result from the updated state.
// ---------------------------------------------------------------------------
module gpioc_regs
   import gpioc_pkg::*;
#(
   parameter int LINES = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step_en,
   input  wire req_type req,
   output rsp_type      rsp
);

   logic [LINES-1:0] dir_ff,   dir_in;
   logic [LINES-1:0] latch_ff, latch_in;
   logic [LINES-1:0] lvl_ff,   lvl_in;
   logic [LINES-1:0] pol_ff,   pol_in;
   logic [LINES-1:0] rise_ff,  rise_in;
   logic [LINES-1:0] fall_ff,  fall_in;
   logic [LINES-1:0] mask_ff,  mask_in;
   logic [LINES-1:0] en_ff,    en_in;
   logic [LINES-1:0] pend_ff,  pend_in;
   logic [LINES-1:0] prev_ff,  prev_in;

   logic [LINES-1:0] pins;
   logic [LINES-1:0] wval;
   logic [LINES-1:0] hit;
   logic [LINES-1:0] rd_val;

   assign pins = req.pin_levels[LINES-1:0];
   assign wval = req.write_data[LINES-1:0];

   gpioc_detect #(.LINES(LINES)) u_detect (
      .pins       (pins),
      .prev_pins  (prev_ff),
      .rise_en    (rise_ff),
      .fall_en    (fall_ff),
      .level_mode (lvl_ff),
      .polarity   (pol_ff),
      .hit        (hit)
   );

   // select read value
   always_comb begin
      unique case (req.reg_index)
         REG_DIR:  rd_val = dir_ff;
         REG_MODE: rd_val = lvl_ff;
         REG_POL:  rd_val = pol_ff;
         REG_RISE: rd_val = rise_ff;
         REG_FALL: rd_val = fall_ff;
         REG_DATA: rd_val = (latch_ff & dir_ff) | (pins & ~dir_ff);
         REG_MASK: rd_val = mask_ff;
         REG_EN:   rd_val = en_ff;
         REG_PEND: rd_val = pend_ff;
         default:  rd_val = '0;
      endcase
   end

   // compute next state for the current item
   always_comb begin
      dir_in   = dir_ff;
      latch_in = latch_ff;
      lvl_in   = lvl_ff;
      pol_in   = pol_ff;
      rise_in  = rise_ff;
      fall_in  = fall_ff;
      mask_in  = mask_ff;
      en_in    = en_ff;
      pend_in  = pend_ff;
      prev_in  = prev_ff;
      if (step_en) begin
         unique case (req.mode)
            MODE_TICK: begin
               pend_in = pend_ff | hit;
               prev_in = pins;
            end
            MODE_WRITE: begin
               unique case (req.reg_index)
                  REG_DIR:  dir_in   = wval;
                  REG_MODE: lvl_in   = wval;
                  REG_POL:  pol_in   = wval;
                  REG_RISE: rise_in  = wval;
                  REG_FALL: fall_in  = wval;
                  REG_DATA: latch_in = wval;
                  REG_SET:  latch_in = latch_ff | wval;
                  REG_CLR:  latch_in = latch_ff & ~wval;
                  REG_MASK: mask_in  = wval;
                  REG_EN:   en_in    = wval;
                  REG_ACK:  pend_in  = pend_ff & ~wval;
                  default:  ;
               endcase
            end
            default: ;
         endcase
      end
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff   <= '0;
         latch_ff <= '0;
         lvl_ff   <= '0;
         pol_ff   <= '0;
         rise_ff  <= '0;
         fall_ff  <= '0;
         mask_ff  <= '1;
         en_ff    <= '0;
         pend_ff  <= '0;
         prev_ff  <= '0;
      end else begin
         dir_ff   <= dir_in;
         latch_ff <= latch_in;
         lvl_ff   <= lvl_in;
         pol_ff   <= pol_in;
         rise_ff  <= rise_in;
         fall_ff  <= fall_in;
         mask_ff  <= mask_in;
         en_ff    <= en_in;
         pend_ff  <= pend_in;
         prev_ff  <= prev_in;
      end
   end

   // form the result from the updated state
   assign rsp.read_data         = (req.mode == MODE_READ) ? 16'(rd_val) : 16'd0;
   assign rsp.pin_drive         = 16'(latch_in);
   assign rsp.pin_output_enable = 16'(dir_in);
   assign rsp.irq_line          = |(pend_in & en_in & ~mask_in);

endmodule : gpioc_regs
`default_nettype wire

[rtl/core/gpioc_checker.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// gpioc_checker: port-level checks of the GPIO controller
// Watches the handshake ports over time; bound to the top level.
// ---------------------------------------------------------------------------
module gpioc_checker
   import gpioc_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response dropped or changed");

   // drop responses on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // accept requests whenever the response side is empty
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

   // expect a valid response after each request transfer
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ##2 rsp_valid)
      else $error("no response two cycles after request transfer");

endmodule : gpioc_checker

bind gpio_controller_with_edge_level_irq_unit gpioc_checker u_gpioc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the 16-line GPIO controller
// Sends pin sample ticks, register reads and register writes over the
// request channel and checks every response against a cycle-free model of
// the register file, the pending latches and the interrupt line. Both
// channels stall at random; a directed opening covers the corner cases.
// ---------------------------------------------------------------------------
module tb_top;
   import gpioc_pkg::*;

   localparam int          RESET_CYCLES = 11;
   localparam int          IDLE_PCT     = 26;
   localparam int          RANDOM_OPS   = 2000;
   localparam int          CALM_START   = 1500;
   localparam int          CALM_END     = 2200;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          SETTLE       = 8;
   localparam logic [1:0]  MODE_SPARE   = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type gpio_op_q[$];
   rsp_type gpio_result_q[$];
   logic    req_took = 1'b0;
   int      cycle_count = 0;
   int      mismatch_count = 0;
   logic [15:0] stim_pins = '0;

   // register file copy, at its reset values
   logic [15:0] sim_dir   = '0;
   logic [15:0] sim_latch = '0;
   logic [15:0] sim_level = '0;
   logic [15:0] sim_pol   = '0;
   logic [15:0] sim_rise  = '0;
   logic [15:0] sim_fall  = '0;
   logic [15:0] sim_mask  = '1;
   logic [15:0] sim_en    = '0;
   logic [15:0] sim_pend  = '0;
   logic [15:0] sim_prev  = '0;

   gpio_controller_with_edge_level_irq_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run one operation against the register file copy and build its response
   function automatic rsp_type gpio_execute(input req_type op);
      rsp_type     res;
      logic [15:0] rise_hit, fall_hit, active, hit;
      res = '0;
      case (op.mode)
         MODE_TICK: begin
            rise_hit = op.pin_levels & ~sim_prev & sim_rise;
            fall_hit = ~op.pin_levels & sim_prev & sim_fall;
            active   = (op.pin_levels & sim_pol) | (~op.pin_levels & ~sim_pol);
            hit      = (~sim_level & (rise_hit | fall_hit)) | (sim_level & active);
            sim_pend = sim_pend | hit;
            sim_prev = op.pin_levels;
         end
         MODE_READ: begin
            case (op.reg_index)
               REG_DIR:  res.read_data = sim_dir;
               REG_MODE: res.read_data = sim_level;
               REG_POL:  res.read_data = sim_pol;
               REG_RISE: res.read_data = sim_rise;
               REG_FALL: res.read_data = sim_fall;
               REG_DATA: res.read_data = (sim_latch & sim_dir) | (op.pin_levels & ~sim_dir);
               REG_MASK: res.read_data = sim_mask;
               REG_EN:   res.read_data = sim_en;
               REG_PEND: res.read_data = sim_pend;
               default:  res.read_data = '0;
            endcase
         end
         MODE_WRITE: begin
            case (op.reg_index)
               REG_DIR:  sim_dir   = op.write_data;
               REG_MODE: sim_level = op.write_data;
               REG_POL:  sim_pol   = op.write_data;
               REG_RISE: sim_rise  = op.write_data;
               REG_FALL: sim_fall  = op.write_data;
               REG_DATA: sim_latch = op.write_data;
               REG_SET:  sim_latch = sim_latch | op.write_data;
               REG_CLR:  sim_latch = sim_latch & ~op.write_data;
               REG_MASK: sim_mask  = op.write_data;
               REG_EN:   sim_en    = op.write_data;
               REG_ACK:  sim_pend  = sim_pend & ~op.write_data;
               default: ;
            endcase
         end
         default: ;
      endcase
      res.pin_drive         = sim_latch;
      res.pin_output_enable = sim_dir;
      res.irq_line          = |(sim_pend & sim_en & ~sim_mask);
      return res;
   endfunction

   task automatic report_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("cycle %0d: %s mismatch, expected %h, got %h",
                     cycle_count, field, want, got);
      end
   endtask

   task automatic queue_op(input logic [1:0] mode, input logic [3:0] idx,
                           input logic [15:0] data, input logic [15:0] pins);
      req_type op;
      op.mode       = mode;
      op.reg_index  = idx;
      op.write_data = data;
      op.pin_levels = pins;
      gpio_op_q.push_back(op);
   endtask

   // Mostly mapped registers; pins often drift one line at a time, else jump to a random word or hold
   task automatic queue_random_ops(input int count);
      int          pick;
      logic [1:0]  mode;
      logic [3:0]  idx;
      logic [15:0] data;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         mode = (pick < 40) ? MODE_TICK : (pick < 65) ? MODE_READ :
                (pick < 96) ? MODE_WRITE : MODE_SPARE;
         do begin
            idx = 4'($urandom_range(15));
         end while (((idx > REG_CLR && idx < REG_MASK) || idx > REG_ACK) &&
                    $urandom_range(99) < 75);
         data = 16'($urandom);
         if (idx == REG_ACK && $urandom_range(1) == 1)
            data = 16'd1 << $urandom_range(15);
         pick = $urandom_range(99);
         if (pick < 50)
            stim_pins = stim_pins ^ (16'd1 << $urandom_range(15));
         else if (pick < 80)
            stim_pins = 16'($urandom);
         queue_op(mode, idx, data, stim_pins);
      end
   endtask

   // Hold until every queued transfer has gone out and every response is in
   task automatic wait_drained();
      while (gpio_op_q.size() != 0 || req_valid || gpio_result_q.size() != 0)
         @(posedge clock);
   endtask

   // Timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Drive the request channel and the response stall at the falling edge
   always @(negedge clock) begin : drive_ports
      logic calm;
      calm = (cycle_count >= CALM_START && cycle_count < CALM_END);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (gpio_op_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            req_data  <= gpio_op_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // Record request transfers and check response transfers at the rising edge
   always @(posedge clock) begin : watch_ports
      rsp_type want;
      req_took = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_took = 1'b1;
            gpio_result_q.push_back(gpio_execute(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (gpio_result_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("cycle %0d: response with none outstanding, got %h",
                           cycle_count, rsp_data);
            end else begin
               want = gpio_result_q.pop_front();
               report_field("read_data", want.read_data, rsp_data.read_data);
               report_field("pin_drive", want.pin_drive, rsp_data.pin_drive);
               report_field("pin_output_enable", want.pin_output_enable,
                            rsp_data.pin_output_enable);
               report_field("irq_line", 16'(want.irq_line), 16'(rsp_data.irq_line));
            end
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values, then a mixed-direction data read
      queue_op(MODE_READ,  REG_MASK, 16'h0000, 16'h0000);
      queue_op(MODE_READ,  REG_DIR,  16'hFFFF, 16'hFFFF);
      queue_op(MODE_WRITE, REG_DIR,  16'h00FF, 16'h0000);
      queue_op(MODE_WRITE, REG_DATA, 16'hA5A5, 16'h0000);
      queue_op(MODE_READ,  REG_DATA, 16'h0000, 16'h3C3C);
      queue_op(MODE_WRITE, REG_SET,  16'h0F00, 16'h0000);
      queue_op(MODE_WRITE, REG_CLR,  16'h0005, 16'h0000);
      // write-only registers read back as zero
      queue_op(MODE_READ,  REG_SET,  16'h0000, 16'hFFFF);
      queue_op(MODE_READ,  REG_CLR,  16'h0000, 16'hFFFF);
      queue_op(MODE_READ,  REG_ACK,  16'h0000, 16'hFFFF);
      // line 0 rising edge, line 1 falling edge, lines 2 and 3 level high / low
      queue_op(MODE_WRITE, REG_RISE, 16'h0001, 16'h0000);
      queue_op(MODE_WRITE, REG_FALL, 16'h0002, 16'h0000);
      queue_op(MODE_WRITE, REG_MODE, 16'h000C, 16'h0000);
      queue_op(MODE_WRITE, REG_POL,  16'h0004, 16'h0000);
      queue_op(MODE_WRITE, REG_EN,   16'hFFFF, 16'h0000);
      queue_op(MODE_WRITE, REG_MASK, 16'h0000, 16'h0000);
      queue_op(MODE_TICK,  REG_DIR,  16'h0000, 16'h0000);
      queue_op(MODE_TICK,  REG_DIR,  16'h0000, 16'h0003);
      queue_op(MODE_TICK,  REG_DIR,  16'h0000, 16'h0000);
      queue_op(MODE_READ,  REG_PEND, 16'h0000, 16'h0000);
      // pending is read only; acknowledge clears it
      queue_op(MODE_WRITE, REG_PEND, 16'h0000, 16'h0000);
      queue_op(MODE_WRITE, REG_ACK,  16'hFFFF, 16'h0000);
      // unmapped indexes and the spare mode do nothing
      queue_op(MODE_READ,  4'd8,     16'h0000, 16'hFFFF);
      queue_op(MODE_WRITE, 4'd15,    16'hFFFF, 16'hFFFF);
      queue_op(MODE_SPARE, REG_DATA, 16'hFFFF, 16'hFFFF);
      wait_drained();

      // random traffic, with a full drain halfway through
      queue_random_ops(RANDOM_OPS / 2);
      wait_drained();
      queue_random_ops(RANDOM_OPS / 2);
      wait_drained();
      repeat (SETTLE) @(posedge clock);

      if (mismatch_count == 0 && gpio_result_q.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule : tb_top

[files.f]
rtl/core/gpioc_pkg.sv
rtl/core/gpioc_detect.sv
rtl/core/gpioc_regs.sv
rtl/core/gpio_controller_with_edge_level_irq_unit.sv
rtl/core/gpioc_checker.sv
bench/tb_top.sv
